FILE: hw/rtl/s2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2d_pkg
// Shared types, constants and helpers for the signed integer to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package s2d_pkg;

	localparam int VALUE_W    = 32;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int CNT_W      = 5;
	localparam int IDX_W      = 4;
	localparam int CHAR_W     = 8;

	localparam logic [CNT_W-1:0]  LAST_SHIFT = CNT_W'(VALUE_W - 1);
	localparam logic [CHAR_W-1:0] MINUS_CODE = 8'd45;
	localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd48;

	typedef enum logic [1:0] {
		DAB_IDLE,
		DAB_SHIFT,
		DAB_DONE
	} dab_state_t;

	typedef enum logic [1:0] {
		EMIT_IDLE,
		EMIT_SIGN,
		EMIT_DIGIT
	} emit_state_t;

	// Finished conversion handed from the dabble unit to the emitter
	typedef struct packed {
		logic             neg;
		logic [BCD_W-1:0] bcd;
	} conv_t;

	// Handoff handshake between the two units
	typedef struct packed {
		logic valid;
		logic take;
	} conv_hs_t;

	function automatic logic [3:0] add3(input logic [3:0] d);
		logic [3:0] r;
		r = (d >= 4'd5) ? (d + 4'd3) : d;
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/s2d_dabble.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2d_dabble
// Bit-serial binary to BCD converter: one shift-add-3 step per cycle.
// ----------------------------------------------------------------------------
module s2d_dabble (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              value_valid,
	output logic                                   value_stall,
	input  wire logic signed [s2d_pkg::VALUE_W-1:0] value,
	output s2d_pkg::conv_t                         conv,
	input  wire logic                              conv_take,
	output logic                                   conv_valid
);

	s2d_pkg::dab_state_t state_q, state_nxt;

	logic [s2d_pkg::VALUE_W-1:0] bin_q;
	logic [s2d_pkg::BCD_W-1:0]   bcd_q;
	logic [s2d_pkg::BCD_W-1:0]   bcd_adj;
	logic [s2d_pkg::CNT_W-1:0]   cnt_q;
	logic                        neg_q;
	logic                        load;
	logic                        shift_en;

	always_comb begin
		for (int i = 0; i < s2d_pkg::NUM_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = s2d_pkg::add3(bcd_q[4*i +: 4]);
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			s2d_pkg::DAB_IDLE: begin
				if (value_valid) state_nxt = s2d_pkg::DAB_SHIFT;
			end
			s2d_pkg::DAB_SHIFT: begin
				if (cnt_q == s2d_pkg::LAST_SHIFT) state_nxt = s2d_pkg::DAB_DONE;
			end
			s2d_pkg::DAB_DONE: begin
				if (conv_take) state_nxt = s2d_pkg::DAB_IDLE;
			end
			default: state_nxt = s2d_pkg::DAB_IDLE;
		endcase
	end

	always_comb begin
		value_stall = 1'b1;
		conv_valid  = 1'b0;
		load        = 1'b0;
		shift_en    = 1'b0;
		unique case (state_q)
			s2d_pkg::DAB_IDLE: begin
				value_stall = 1'b0;
				load        = value_valid;
			end
			s2d_pkg::DAB_SHIFT: shift_en   = 1'b1;
			s2d_pkg::DAB_DONE:  conv_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= s2d_pkg::DAB_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (load) cnt_q <= '0;
			else if (shift_en) cnt_q <= cnt_q + 1'b1;
		end
	end

	// Magnitude through unsigned negate so the most negative value works
	always_ff @(posedge clk) begin
		if (load) begin
			neg_q <= value[s2d_pkg::VALUE_W-1];
			bin_q <= value[s2d_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
			bcd_q <= '0;
		end else if (shift_en) begin
			bcd_q <= {bcd_adj[s2d_pkg::BCD_W-2:0], bin_q[s2d_pkg::VALUE_W-1]};
			bin_q <= {bin_q[s2d_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	assign conv.neg = neg_q;
	assign conv.bcd = bcd_q;

endmodule
`default_nettype wire

FILE: hw/rtl/s2d_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s2d_emit
// Character emitter: optional minus sign, then BCD digits from the leading one down,
// through a registered output stage.
// ----------------------------------------------------------------------------
module s2d_emit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire s2d_pkg::conv_t                conv,
	input  wire logic                          conv_valid,
	output logic                               conv_take,
	output logic                               character_valid,
	input  wire logic                          character_stall,
	output logic [s2d_pkg::CHAR_W-1:0]         character,
	output logic                               final_char
);

	s2d_pkg::emit_state_t state_q, state_nxt;

	logic [s2d_pkg::BCD_W-1:0] digits_q;
	logic [s2d_pkg::IDX_W-1:0] idx_q;
	logic [s2d_pkg::IDX_W-1:0] msd;
	logic [3:0]                cur_digit;
	logic                      out_free;
	logic                      load;
	logic                      emit_sign;
	logic                      emit_digit;
	logic                      valid_q;
	logic [s2d_pkg::CHAR_W-1:0] char_q;
	logic                      final_q;

	assign out_free  = !valid_q || !character_stall;
	assign cur_digit = digits_q[{idx_q, 2'b00} +: 4];

	// Leading nonzero digit; zero keeps a single digit
	always_comb begin
		msd = '0;
		for (int i = 0; i < s2d_pkg::NUM_DIGITS; i++) begin
			if (conv.bcd[4*i +: 4] != 4'd0) msd = s2d_pkg::IDX_W'(i);
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			s2d_pkg::EMIT_IDLE: begin
				if (conv_valid)
					state_nxt = conv.neg ? s2d_pkg::EMIT_SIGN : s2d_pkg::EMIT_DIGIT;
			end
			s2d_pkg::EMIT_SIGN: begin
				if (out_free) state_nxt = s2d_pkg::EMIT_DIGIT;
			end
			s2d_pkg::EMIT_DIGIT: begin
				if (out_free && idx_q == '0) state_nxt = s2d_pkg::EMIT_IDLE;
			end
			default: state_nxt = s2d_pkg::EMIT_IDLE;
		endcase
	end

	always_comb begin
		conv_take  = 1'b0;
		load       = 1'b0;
		emit_sign  = 1'b0;
		emit_digit = 1'b0;
		unique case (state_q)
			s2d_pkg::EMIT_IDLE: begin
				conv_take = 1'b1;
				load      = conv_valid;
			end
			s2d_pkg::EMIT_SIGN:  emit_sign  = out_free;
			s2d_pkg::EMIT_DIGIT: emit_digit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= s2d_pkg::EMIT_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_free) valid_q <= emit_sign || emit_digit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= conv.bcd;
			idx_q    <= msd;
		end else if (emit_digit && idx_q != '0) begin
			idx_q <= idx_q - 1'b1;
		end
		if (emit_sign) begin
			char_q  <= s2d_pkg::MINUS_CODE;
			final_q <= 1'b0;
		end else if (emit_digit) begin
			char_q  <= s2d_pkg::DIGIT_BASE + {4'd0, cur_digit};
			final_q <= (idx_q == '0);
		end
	end

	assign character_valid = valid_q;
	assign character       = char_q;
	assign final_char      = final_q;

endmodule
`default_nettype wire

FILE: hw/rtl/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed 32-bit integer into its decimal ASCII text, one
// character per output transaction, last character flagged.
// ----------------------------------------------------------------------------
// A value is taken while the converter is idle and converted to BCD by a
// bit-serial shift-add-3 unit, one magnitude bit per cycle; the converter
// then holds the BCD word until the emitter, once idle, takes it. The
// emitter sends an optional minus sign and then one digit per cycle while
// the output does not stall, from the leading nonzero digit, 1 to 11
// characters, through an output register. The converter accepts the next
// value while the emitter is still sending.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               value_valid,
	output logic                                    value_stall,
	input  wire logic signed [s2d_pkg::VALUE_W-1:0] value,
	output logic                                    character_valid,
	input  wire logic                               character_stall,
	output logic [s2d_pkg::CHAR_W-1:0]              character,
	output logic                                    final_char
);

	s2d_pkg::conv_t    conv;
	s2d_pkg::conv_hs_t conv_hs;
	logic              conv_take;
	logic              conv_valid;

	assign conv_hs.valid = conv_valid;
	assign conv_hs.take  = conv_take;

	s2d_dabble u_dabble (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.conv        (conv),
		.conv_take   (conv_hs.take),
		.conv_valid  (conv_valid)
	);

	s2d_emit u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.conv            (conv),
		.conv_valid      (conv_valid),
		.conv_take       (conv_take),
		.character_valid (character_valid),
		.character_stall (character_stall),
		.character       (character),
		.final_char      (final_char)
	);

	// Converter goes busy right after it takes a value
	assert property (@(posedge clk) disable iff (!arst_n)
		(value_valid && !value_stall) |=> value_stall)
		else $error("converter accepted a value but did not go busy");

	// Every character is a minus sign or a decimal digit
	assert property (@(posedge clk) disable iff (!arst_n)
		character_valid |-> (character == s2d_pkg::MINUS_CODE ||
			(character >= s2d_pkg::DIGIT_BASE && character <= 8'd57)))
		else $error("character is neither minus sign nor digit");

	// A minus sign never ends a number
	assert property (@(posedge clk) disable iff (!arst_n)
		(character_valid && character == s2d_pkg::MINUS_CODE) |-> !final_char)
		else $error("minus sign flagged as last character");

	// After a handoff the finished conversion is no longer offered
	assert property (@(posedge clk) disable iff (!arst_n)
		(conv_hs.valid && conv_hs.take) |=> !conv_hs.valid)
		else $error("conversion result handed off twice");

endmodule
`default_nettype wire

FILE: dv/signed_int_to_decimal_ascii_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb
// Drives signed 32-bit values into the converter with random gaps and output
// stalls, predicts the decimal ASCII text of each accepted value and checks
// every character and its last-character flag in order.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_tb;

	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD  = 400;
	localparam int HOLD_AT    = 80;

	typedef struct packed {
		logic [s2d_pkg::CHAR_W-1:0] code;
		logic                       last;
	} text_char_t;

	typedef struct {
		logic signed [s2d_pkg::VALUE_W-1:0] val;
		int unsigned                        gap;
		bit                                 drain;
	} conv_request_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               value_valid = 1'b0;
	logic                               value_stall;
	logic signed [s2d_pkg::VALUE_W-1:0] value = '0;
	logic                               character_valid;
	logic                               character_stall = 1'b0;
	logic [s2d_pkg::CHAR_W-1:0]         character;
	logic                               final_char;

	conv_request_t pending_requests[$];
	text_char_t    expected_text[$];

	int          values_sent = 0;
	int          values_negative = 0;
	int          longest_text = 0;
	int          chars_predicted = 0;
	int          chars_seen = 0;
	int          fails = 0;
	int          idle_cycles = 0;
	bit          head_armed;
	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned hold_left;
	bit          nxt_valid;

	signed_int_to_decimal_ascii_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.value_valid     (value_valid),
		.value_stall     (value_stall),
		.value           (value),
		.character_valid (character_valid),
		.character_stall (character_stall),
		.character       (character),
		.final_char      (final_char)
	);

	always #1 clk = ~clk;

	// Expected text of one value: optional minus, then digits MSD first.
	function automatic void queue_decimal_text(
		input logic signed [s2d_pkg::VALUE_W-1:0] v);
		logic [s2d_pkg::VALUE_W-1:0] mag;
		logic [3:0]                  digs[s2d_pkg::NUM_DIGITS];
		int                          ndig;
		int                          len;
		text_char_t                  c;
		mag  = v[s2d_pkg::VALUE_W-1] ? (32'd0 - v) : v;
		ndig = 0;
		do begin
			digs[ndig] = 4'(mag % 10);
			mag        = mag / 10;
			ndig++;
		end while (mag != 0 && ndig < s2d_pkg::NUM_DIGITS);
		len = ndig;
		if (v[s2d_pkg::VALUE_W-1]) begin
			c.code = s2d_pkg::MINUS_CODE;
			c.last = 1'b0;
			expected_text.push_back(c);
			values_negative++;
			len++;
		end
		for (int k = ndig - 1; k >= 0; k--) begin
			c.code = s2d_pkg::DIGIT_BASE + s2d_pkg::CHAR_W'(digs[k]);
			c.last = (k == 0);
			expected_text.push_back(c);
		end
		chars_predicted += len;
		if (len > longest_text)
			longest_text = len;
	endfunction

	task automatic add_value(input logic [s2d_pkg::VALUE_W-1:0] v, input bit drain);
		conv_request_t r;
		int            idx;
		idx     = pending_requests.size();
		r.val   = v;
		r.drain = drain;
		// back-to-back stretch with no sender gaps
		r.gap   = (idx >= 90 && idx < 130) ? 0 : $urandom_range(0, 13);
		pending_requests.push_back(r);
	endtask

	// Driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_valid <= 1'b0;
			value       <= '0;
			head_armed  = 1'b0;
			gap_left    = 0;
		end else if (!(value_valid && value_stall)) begin
			nxt_valid = 1'b0;
			if (value_valid) begin
				queue_decimal_text(value);
				values_sent++;
			end
			if (pending_requests.size() > 0) begin
				if (!head_armed) begin
					gap_left   = pending_requests[0].gap;
					head_armed = 1'b1;
				end
				if (pending_requests[0].drain && chars_seen != chars_predicted) begin
					// hold until every expected character has come out
				end else if (gap_left > 0) begin
					gap_left--;
				end else begin
					nxt_valid  = 1'b1;
					value     <= pending_requests[0].val;
					pending_requests.pop_front();
					head_armed = 1'b0;
				end
			end
			value_valid <= nxt_valid;
		end
	end

	// Monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			character_stall <= 1'b0;
			chars_seen      <= 0;
			stall_left      = 0;
			hold_left       = 0;
		end else begin
			if (character_valid && !character_stall) begin
				if (expected_text.size() == 0) begin
					$display("%0t: unexpected character %0d final %0b",
						$time, character, final_char);
					fails++;
				end else if (expected_text[0] != {character, final_char}) begin
					$display("%0t: expected character %0d final %0b, got %0d final %0b",
						$time, expected_text[0].code, expected_text[0].last,
						character, final_char);
					fails++;
					void'(expected_text.pop_front());
				end else begin
					void'(expected_text.pop_front());
				end
				chars_seen <= chars_seen + 1;
				stall_left = (chars_seen >= 300 && chars_seen < 500) ? 0 :
					$urandom_range(0, 13);
				// one long hold-off so the input side backs up
				if (chars_seen == HOLD_AT - 1)
					hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				character_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				character_stall <= 1'b1;
			end else begin
				character_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((value_valid && !value_stall) || (character_valid && !character_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int unsigned nd;
		int unsigned lo;
		int unsigned hi;
		int unsigned mag;
		int          values_total;
		logic [s2d_pkg::VALUE_W-1:0] v;

		// directed: zero, sign edges, digit-count boundaries, ten-digit extremes
		add_value(32'd0, 1'b0);
		add_value(32'd1, 1'b0);
		add_value(-32'sd1, 1'b0);
		add_value(32'd9, 1'b0);
		add_value(32'd10, 1'b0);
		add_value(-32'sd10, 1'b0);
		add_value(32'd99, 1'b0);
		add_value(32'd100, 1'b0);
		add_value(32'h7FFF_FFFF, 1'b0);
		add_value(32'h8000_0000, 1'b0);
		add_value(32'h8000_0001, 1'b0);
		add_value(32'd999999999, 1'b0);
		add_value(32'd1000000000, 1'b0);
		add_value(-32'sd1000000000, 1'b0);
		add_value(32'd1234567890, 1'b0);
		add_value(-32'sd999999999, 1'b0);
		add_value(32'd1000000009, 1'b0);
		add_value(32'h5555_5555, 1'b0);
		add_value(32'hAAAA_AAAA, 1'b0);
		add_value(32'd7, 1'b0);

		// random: mostly a random digit count, some raw 32-bit patterns
		for (int i = 0; i < 160; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				v = $urandom;
			end else begin
				nd  = $urandom_range(1, 10);
				lo  = 1;
				for (int k = 1; k < nd; k++)
					lo = lo * 10;
				if (nd == 1)
					lo = 0;
				hi  = (nd == 10) ? 32'h7FFF_FFFF : (nd == 1 ? 9 : lo * 10 - 1);
				mag = $urandom_range(hi, lo);
				v   = $urandom_range(0, 1) ? (32'd0 - mag) : mag;
			end
			add_value(v, (i == 30 || i == 120));
		end
		values_total = pending_requests.size();

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// wait for the last value to be accepted, then for its text
		wait (values_sent == values_total);
		wait (chars_seen == chars_predicted);
		repeat (60) @(posedge clk);

		$display("Converted %0d values (%0d negative) into %0d characters,",
			values_sent, values_negative, chars_seen);
		$display("longest text %0d characters, with gaps, stalls and a long output hold.",
			longest_text);
		if (fails == 0 && expected_text.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: signed_int_to_decimal_ascii_unit.f
hw/rtl/s2d_pkg.sv
hw/rtl/s2d_dabble.sv
hw/rtl/s2d_emit.sv
hw/rtl/signed_int_to_decimal_ascii_unit.sv
dv/signed_int_to_decimal_ascii_unit_tb.sv
